[hdl/file_upload_deframer_defines.svh]
// assertion macros for the file upload deframer checker
`ifndef FILE_UPLOAD_DEFRAMER_DEFINES_SVH
`define FILE_UPLOAD_DEFRAMER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define FUD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define FUD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/fud_pkg.sv]
// shared types and constants of the file upload deframer
package fud_pkg;

	localparam int MAX_NAME_LEN = 63;
	localparam int PAGE_BYTES = 256;

	localparam logic [7:0] FLAG_START = 8'h7E;
	localparam logic [7:0] FLAG_ESC = 8'h7D;
	localparam logic [7:0] FLAG_SEP = 8'h7C;
	localparam logic [7:0] ESC_XOR = 8'h20;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_LEN = 3'd2;
	localparam logic [2:0] PH_LSEP = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;
	localparam logic [2:0] PH_END = 3'd6;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_NAME = 3'd1;
	localparam logic [2:0] EV_HEADER = 3'd2;
	localparam logic [2:0] EV_STORE = 3'd3;
	localparam logic [2:0] EV_SKIP = 3'd4;
	localparam logic [2:0] EV_END = 3'd5;
	localparam logic [2:0] EV_ABORT = 3'd6;
	localparam logic [2:0] EV_TIMEOUT = 3'd7;

	localparam logic [2:0] AB_NONE = 3'd0;
	localparam logic [2:0] AB_NAME_LONG = 3'd1;
	localparam logic [2:0] AB_NO_LSEP = 3'd2;
	localparam logic [2:0] AB_NO_END = 3'd3;
	localparam logic [2:0] AB_OPEN_FAIL = 3'd4;

	localparam logic [1:0] REPLY_OK = 2'd0;
	localparam logic [1:0] REPLY_REFUSED = 2'd1;

	localparam logic [0:0] KIND_TIMEOUT = 1'b1;

	localparam logic [7:0] REG_NAME_LIMIT = 8'd0;
	localparam logic [7:0] REG_PAGE_SIZE = 8'd1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic [1:0] storage_reply;
	} item_t;

	typedef struct packed {
		logic [5:0] name_limit;
		logic [8:0] page_size;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  out_byte;
		logic [31:0] file_length;
		logic        page_end;
		logic        body_done;
		logic [2:0]  abort_code;
		logic [31:0] good_files;
		logic [31:0] failed_files;
		logic [2:0]  parse_state;
	} result_t;

endpackage

[hdl/fud_in_reg.sv]
// input register stage of the file upload deframer
module fud_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,
	input  logic          s_tuser,
	input  logic          advance,
	output logic          valid_s1,
	output fud_pkg::item_t item_s1
);
	import fud_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind <= s_tuser;
			item_s1.rx_byte <= s_tdata[7:0];
			item_s1.storage_reply <= s_tdata[9:8];
		end
	end
endmodule

[hdl/fud_parser.sv]
// frame parser state and per-item update of the file upload deframer
module fud_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  fud_pkg::cfg_t    cfg,
	input  logic            fire,
	input  fud_pkg::item_t   item,
	output fud_pkg::result_t res
);
	import fud_pkg::*;

	logic [2:0]  phase_q, phase_d, phase_eff;
	logic [5:0]  name_count_q, name_count_d;
	logic [2:0]  length_count_q, length_count_d;
	logic [31:0] length_shift_q, length_shift_d;
	logic [31:0] expected_len_q, expected_len_d;
	logic [31:0] body_count_q, body_count_d;
	logic        escape_q, escape_d;
	logic [8:0]  page_count_q, page_count_d;
	logic [31:0] ok_count_q, ok_count_d;
	logic [31:0] fail_count_q, fail_count_d;
	logic [7:0]  limit;
	logic [7:0]  value;
	logic        done;
	logic [31:0] body_inc;
	logic [8:0]  page_inc;

	assign limit = ({2'b00, cfg.name_limit} < 8'(MAX_NAME_LEN)) ?
		{2'b00, cfg.name_limit} : 8'(MAX_NAME_LEN);
	assign phase_eff = (phase_q > PH_END) ? PH_IDLE : phase_q;
	assign body_inc = body_count_q + 32'd1;
	assign page_inc = page_count_q + 9'd1;
	assign value = escape_q ? (item.rx_byte ^ ESC_XOR) : item.rx_byte;
	assign done = (body_inc == expected_len_q);

	always_comb begin
		phase_d = phase_eff;
		name_count_d = name_count_q;
		length_count_d = length_count_q;
		length_shift_d = length_shift_q;
		expected_len_d = expected_len_q;
		body_count_d = body_count_q;
		escape_d = escape_q;
		page_count_d = page_count_q;
		ok_count_d = ok_count_q;
		fail_count_d = fail_count_q;
		res.event_res = EV_NONE;
		res.out_byte = 8'h00;
		res.page_end = 1'b0;
		res.body_done = 1'b0;
		res.abort_code = AB_NONE;
		if (item.kind == KIND_TIMEOUT) begin
			if (phase_eff == PH_BODY) begin
				res.page_end = (page_count_q != 9'd0);
				page_count_d = 9'd0;
			end
			phase_d = PH_IDLE;
			escape_d = 1'b0;
			res.event_res = EV_TIMEOUT;
		end else begin
			unique case (phase_eff)
				PH_IDLE: begin
					if (item.rx_byte == FLAG_START) begin
						name_count_d = 6'd0;
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					if (item.rx_byte == FLAG_SEP) begin
						length_count_d = 3'd0;
						length_shift_d = 32'd0;
						phase_d = PH_LEN;
					end else if ({2'b00, name_count_q} < limit) begin
						name_count_d = name_count_q + 6'd1;
						res.event_res = EV_NAME;
						res.out_byte = item.rx_byte;
					end else begin
						fail_count_d = fail_count_q + 32'd1;
						phase_d = PH_IDLE;
						name_count_d = 6'd0;
						escape_d = 1'b0;
						res.event_res = EV_ABORT;
						res.abort_code = AB_NAME_LONG;
					end
				end
				PH_LEN: begin
					length_shift_d = {length_shift_q[23:0], item.rx_byte};
					length_count_d = length_count_q + 3'd1;
					if (length_count_d[2]) begin
						expected_len_d = length_shift_d;
						phase_d = PH_LSEP;
					end
				end
				PH_LSEP: begin
					if (item.rx_byte != FLAG_SEP) begin
						fail_count_d = fail_count_q + 32'd1;
						phase_d = PH_IDLE;
						name_count_d = 6'd0;
						escape_d = 1'b0;
						res.event_res = EV_ABORT;
						res.abort_code = AB_NO_LSEP;
					end else begin
						body_count_d = 32'd0;
						escape_d = 1'b0;
						page_count_d = 9'd0;
						if (item.storage_reply == REPLY_OK) begin
							phase_d = PH_BODY;
							res.event_res = EV_HEADER;
						end else if (item.storage_reply == REPLY_REFUSED) begin
							phase_d = PH_SKIP;
							res.event_res = EV_HEADER;
						end else begin
							fail_count_d = fail_count_q + 32'd1;
							name_count_d = 6'd0;
							phase_d = PH_SKIP;
							res.event_res = EV_ABORT;
							res.abort_code = AB_OPEN_FAIL;
						end
					end
				end
				PH_BODY, PH_SKIP: begin
					if (!escape_q && item.rx_byte == FLAG_ESC) begin
						escape_d = 1'b1;
					end else begin
						escape_d = 1'b0;
						body_count_d = body_inc;
						res.body_done = done;
						if (phase_eff == PH_BODY) begin
							res.event_res = EV_STORE;
							res.out_byte = value;
							page_count_d = page_inc;
							if (page_inc == cfg.page_size || done) begin
								res.page_end = 1'b1;
								page_count_d = 9'd0;
							end
							if (done) begin
								ok_count_d = ok_count_q + 32'd1;
							end
						end else begin
							res.event_res = EV_SKIP;
						end
						if (done) begin
							phase_d = PH_END;
						end
					end
				end
				default: begin
					if (item.rx_byte == FLAG_START) begin
						phase_d = PH_IDLE;
						res.event_res = EV_END;
					end else begin
						fail_count_d = fail_count_q + 32'd1;
						phase_d = PH_IDLE;
						name_count_d = 6'd0;
						escape_d = 1'b0;
						res.event_res = EV_ABORT;
						res.abort_code = AB_NO_END;
					end
				end
			endcase
		end
		res.file_length = expected_len_d;
		res.good_files = ok_count_d;
		res.failed_files = fail_count_d;
		res.parse_state = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			name_count_q <= 6'd0;
			length_count_q <= 3'd0;
			length_shift_q <= 32'd0;
			expected_len_q <= 32'd0;
			body_count_q <= 32'd0;
			escape_q <= 1'b0;
			page_count_q <= 9'd0;
			ok_count_q <= 32'd0;
			fail_count_q <= 32'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			name_count_q <= name_count_d;
			length_count_q <= length_count_d;
			length_shift_q <= length_shift_d;
			expected_len_q <= expected_len_d;
			body_count_q <= body_count_d;
			escape_q <= escape_d;
			page_count_q <= page_count_d;
			ok_count_q <= ok_count_d;
			fail_count_q <= fail_count_d;
		end
	end
endmodule

[hdl/fud_out_reg.sv]
// result register stage of the file upload deframer
module fud_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  fud_pkg::result_t res,
	output logic             advance,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [111:0]     m_tdata,
	output logic [2:0]       m_tuser
);
	import fud_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign advance = !valid_s2 || m_tready;
	assign m_tvalid = valid_s2;
	assign m_tuser = res_s2.event_res;
	assign m_tdata = {res_s2.parse_state, res_s2.failed_files, res_s2.good_files,
		res_s2.abort_code, res_s2.body_done, res_s2.page_end, res_s2.file_length,
		res_s2.out_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end
endmodule

[hdl/file_upload_deframer.sv]
// top level of the file upload deframer
// usage:
// - slave stream takes one item per handshake: a received byte with the storage
//   reply, or an idle-timeout tick flagged on s_tuser
// - master stream gives exactly one result item per input item, with the event
//   code on m_tuser and the byte, length, marks, abort code, file counts and
//   parser state on m_tdata
// - config channel writes name_limit (index 0) or page_size (index 1); it is
//   always ready and is meant to be written only while the block is idle
// - an accepted item waits in the input register; its result is captured in the result register when advance is high
// - throughput: one item per cycle while the receiver takes results, with the parser
//   update combinational between the input register and the result register
// - a stalled receiver holds the result; one more item is taken into the input
//   register, then s_tready drops until the result is taken
// - reset clears the parser state, counts and both stages, and restores the
//   registers to name_limit 63 and page_size 256
module file_upload_deframer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // rx_byte[7:0], storage_reply[9:8], zero pad
	input  logic         s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // out_byte, file_length, page_end, body_done,
	                               // abort_code, good_files, failed_files, parse_state
	output logic [2:0]   m_tuser,  // event_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import fud_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	result_t res;
	logic    valid_s1;
	logic    advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_limit <= 6'd63;
			cfg_q.page_size <= 9'(PAGE_BYTES);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NAME_LIMIT) begin
				cfg_q.name_limit <= cfg_data[5:0];
			end else if (cfg_index == REG_PAGE_SIZE) begin
				cfg_q.page_size <= cfg_data[8:0];
			end
		end
	end

	fud_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fud_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (valid_s1 && advance),
		.item   (item_s1),
		.res    (res)
	);

	fud_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule

[hdl/fud_checker.sv]
// port-level assertions of the file upload deframer and their bind
`include "file_upload_deframer_defines.svh"

module fud_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic [2:0]   m_tuser
);
	import fud_pkg::*;

	`FUD_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`FUD_ASSERT(a_timeout_idle, m_tvalid && m_tuser == EV_TIMEOUT |-> m_tdata[111:109] == PH_IDLE, "timeout did not return to idle")
	`FUD_ASSERT(a_abort_code, m_tvalid |-> ((m_tuser == EV_ABORT) == (m_tdata[44:42] != AB_NONE)), "abort code and abort event disagree")
	`FUD_ASSERT(a_page_end, m_tvalid && m_tdata[40] |-> m_tuser == EV_STORE || m_tuser == EV_TIMEOUT, "page end on wrong event")
	`FUD_ASSERT_NEVER(a_accept_full, s_tvalid && s_tready && m_tvalid && !m_tready && !$past(s_tready), "input taken while both stages full")
endmodule

bind file_upload_deframer fud_checker u_fud_checker (.*);

[test/file_upload_deframer_tb.sv]
`timescale 1ns / 1ps
// self-checking stream testbench for the file upload deframer, checked against a frame parser model
module file_upload_deframer_tb;
	import fud_pkg::*;

	localparam logic       KIND_BYTE       = 1'b0;
	localparam logic [1:0] REPLY_OPEN_FAIL = 2'd2;
	localparam logic [1:0] REPLY_OTHER     = 2'd3;

	typedef struct packed {
		logic       typed;
		item_t      it;
		logic [2:0] ev;
		logic [2:0] code;
		logic [2:0] st;
	} frame_row_t;

	localparam frame_row_t DIRECTED [24] = '{
		{1'b1, KIND_BYTE, 8'h00, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_BYTE, FLAG_START, REPLY_OK, EV_NONE, AB_NONE, PH_NAME},
		{1'b1, KIND_BYTE, 8'h61, REPLY_OK, EV_NAME, AB_NONE, PH_NAME},
		{1'b0, KIND_BYTE, 8'hFF, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_BYTE, FLAG_SEP, REPLY_OK, EV_NONE, AB_NONE, PH_LEN},
		{1'b0, KIND_BYTE, 8'h00, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'h00, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'h00, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_BYTE, 8'h03, REPLY_OK, EV_NONE, AB_NONE, PH_LSEP},
		{1'b1, KIND_BYTE, FLAG_SEP, REPLY_OK, EV_HEADER, AB_NONE, PH_BODY},
		{1'b1, KIND_BYTE, FLAG_ESC, REPLY_OK, EV_NONE, AB_NONE, PH_BODY},
		{1'b0, KIND_BYTE, 8'h5E, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, FLAG_START, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_BYTE, FLAG_SEP, REPLY_OK, EV_STORE, AB_NONE, PH_END},
		{1'b1, KIND_BYTE, FLAG_START, REPLY_OK, EV_END, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, FLAG_START, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, FLAG_SEP, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'hFF, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'hFF, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'hFF, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b0, KIND_BYTE, 8'hFF, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_BYTE, FLAG_SEP, REPLY_OTHER, EV_ABORT, AB_OPEN_FAIL, PH_SKIP},
		{1'b0, KIND_BYTE, 8'h00, REPLY_OK, EV_NONE, AB_NONE, PH_IDLE},
		{1'b1, KIND_TIMEOUT, 8'hFF, REPLY_OTHER, EV_TIMEOUT, AB_NONE, PH_IDLE}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	// parser model state
	logic [2:0]  ph;
	logic [5:0]  nm_cnt;
	logic [2:0]  len_cnt;
	logic [31:0] len_sh;
	logic [31:0] exp_len;
	logic [31:0] body_cnt;
	logic        esc;
	logic [8:0]  pg_cnt;
	logic [31:0] good_cnt;
	logic [31:0] bad_cnt;
	logic [5:0]  cfg_name_limit;
	logic [8:0]  cfg_page_size;

	frame_row_t rx_stream[$];
	result_t    pending_results[$];
	frame_row_t cur;
	int         n_mismatch = 0;
	int         n_accepted = 0;
	int         ready_delay = 0;
	bit         hold_on = 1'b0;
	bit         tx_idle = 1'b1;
	bit         rx_idle = 1'b1;

	file_upload_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void reset_model();
		ph = PH_IDLE;
		nm_cnt = '0;
		len_cnt = '0;
		len_sh = '0;
		exp_len = '0;
		body_cnt = '0;
		esc = 1'b0;
		pg_cnt = '0;
		good_cnt = '0;
		bad_cnt = '0;
		cfg_name_limit = 6'd63;
		cfg_page_size = 9'(PAGE_BYTES);
	endfunction

	function automatic void abort_file();
		bad_cnt = bad_cnt + 32'd1;
		ph = PH_IDLE;
		nm_cnt = '0;
		esc = 1'b0;
	endfunction

	function automatic result_t deframe(item_t it);
		result_t    r;
		logic [5:0] lim;
		logic [7:0] v;
		logic       done;
		r = '0;
		lim = (cfg_name_limit < MAX_NAME_LEN) ? cfg_name_limit : 6'(MAX_NAME_LEN);
		if (ph > PH_END)
			ph = PH_IDLE;
		if (it.kind == KIND_TIMEOUT) begin
			if (ph == PH_BODY && pg_cnt != 0)
				r.page_end = 1'b1;
			if (ph == PH_BODY)
				pg_cnt = '0;
			ph = PH_IDLE;
			esc = 1'b0;
			r.event_res = EV_TIMEOUT;
		end else begin
			case (ph)
				PH_IDLE: begin
					if (it.rx_byte == FLAG_START) begin
						nm_cnt = '0;
						ph = PH_NAME;
					end
				end
				PH_NAME: begin
					if (it.rx_byte == FLAG_SEP) begin
						len_cnt = '0;
						len_sh = '0;
						ph = PH_LEN;
					end else if (nm_cnt < lim) begin
						nm_cnt = nm_cnt + 6'd1;
						r.event_res = EV_NAME;
						r.out_byte = it.rx_byte;
					end else begin
						abort_file();
						r.event_res = EV_ABORT;
						r.abort_code = AB_NAME_LONG;
					end
				end
				PH_LEN: begin
					len_sh = {len_sh[23:0], it.rx_byte};
					len_cnt = len_cnt + 3'd1;
					if (len_cnt >= 3'd4) begin
						exp_len = len_sh;
						ph = PH_LSEP;
					end
				end
				PH_LSEP: begin
					if (it.rx_byte != FLAG_SEP) begin
						abort_file();
						r.event_res = EV_ABORT;
						r.abort_code = AB_NO_LSEP;
					end else begin
						body_cnt = '0;
						esc = 1'b0;
						pg_cnt = '0;
						if (it.storage_reply == REPLY_OK) begin
							ph = PH_BODY;
							r.event_res = EV_HEADER;
						end else if (it.storage_reply == REPLY_REFUSED) begin
							ph = PH_SKIP;
							r.event_res = EV_HEADER;
						end else begin
							abort_file();
							ph = PH_SKIP;
							r.event_res = EV_ABORT;
							r.abort_code = AB_OPEN_FAIL;
						end
					end
				end
				PH_BODY, PH_SKIP: begin
					if (!esc && it.rx_byte == FLAG_ESC) begin
						esc = 1'b1;
					end else begin
						v = esc ? (it.rx_byte ^ ESC_XOR) : it.rx_byte;
						esc = 1'b0;
						body_cnt = body_cnt + 32'd1;
						done = (body_cnt == exp_len);
						r.body_done = done;
						if (ph == PH_BODY) begin
							r.event_res = EV_STORE;
							r.out_byte = v;
							pg_cnt = pg_cnt + 9'd1;
							if (pg_cnt == cfg_page_size || done) begin
								r.page_end = 1'b1;
								pg_cnt = '0;
							end
							if (done)
								good_cnt = good_cnt + 32'd1;
						end else begin
							r.event_res = EV_SKIP;
						end
						if (done)
							ph = PH_END;
					end
				end
				// waiting for the end flag
				default: begin
					if (it.rx_byte == FLAG_START) begin
						ph = PH_IDLE;
						r.event_res = EV_END;
					end else begin
						abort_file();
						r.event_res = EV_ABORT;
						r.abort_code = AB_NO_END;
					end
				end
			endcase
		end
		r.file_length = exp_len;
		r.good_files = good_cnt;
		r.failed_files = bad_cnt;
		r.parse_state = ph;
		return r;
	endfunction

	function automatic void mismatch(string what, logic [31:0] want, logic [31:0] seen);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, seen);
	endfunction

	function automatic void compare_result(result_t want, result_t got);
		if (got.event_res !== want.event_res)
			mismatch("event_res", 32'(want.event_res), 32'(got.event_res));
		if (got.out_byte !== want.out_byte)
			mismatch("out_byte", 32'(want.out_byte), 32'(got.out_byte));
		if (got.file_length !== want.file_length)
			mismatch("file_length", want.file_length, got.file_length);
		if (got.page_end !== want.page_end)
			mismatch("page_end", 32'(want.page_end), 32'(got.page_end));
		if (got.body_done !== want.body_done)
			mismatch("body_done", 32'(want.body_done), 32'(got.body_done));
		if (got.abort_code !== want.abort_code)
			mismatch("abort_code", 32'(want.abort_code), 32'(got.abort_code));
		if (got.good_files !== want.good_files)
			mismatch("good_files", want.good_files, got.good_files);
		if (got.failed_files !== want.failed_files)
			mismatch("failed_files", want.failed_files, got.failed_files);
		if (got.parse_state !== want.parse_state)
			mismatch("parse_state", 32'(want.parse_state), 32'(got.parse_state));
	endfunction

	always @(posedge clk) begin
		result_t r;
		result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_NAME_LIMIT)
					cfg_name_limit = cfg_data[5:0];
				else if (cfg_index == REG_PAGE_SIZE)
					cfg_page_size = cfg_data[8:0];
			end
			if (s_tvalid && s_tready) begin
				r = deframe(cur.it);
				if (cur.typed) begin
					r.event_res = cur.ev;
					r.abort_code = cur.code;
					r.parse_state = cur.st;
				end
				pending_results.push_back(r);
				n_accepted++;
			end
			if (m_tvalid && m_tready) begin
				got.event_res = m_tuser;
				got.out_byte = m_tdata[7:0];
				got.file_length = m_tdata[39:8];
				got.page_end = m_tdata[40];
				got.body_done = m_tdata[41];
				got.abort_code = m_tdata[44:42];
				got.good_files = m_tdata[76:45];
				got.failed_files = m_tdata[108:77];
				got.parse_state = m_tdata[111:109];
				if (pending_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("result item with nothing expected, event %0d", got.event_res);
				end else begin
					compare_result(pending_results.pop_front(), got);
				end
				ready_delay = rx_idle ? $urandom_range(0, 13) : 0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !hold_on && ready_delay == 0;
		if (ready_delay > 0)
			ready_delay--;
	end

	// long receiver stall so the input side backs up
	initial begin
		while (n_accepted < 400)
			@(posedge clk);
		hold_on = 1'b1;
		repeat (120) @(posedge clk);
		hold_on = 1'b0;
	end

	function automatic void put(logic k, logic [7:0] b, logic [1:0] rep);
		frame_row_t row;
		row = '0;
		row.it.kind = k;
		row.it.rx_byte = b;
		row.it.storage_reply = rep;
		rx_stream.push_back(row);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		put(KIND_BYTE, b, 2'($urandom_range(0, 3)));
	endfunction

	function automatic void put_timeout();
		put(KIND_TIMEOUT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
	endfunction

	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 9))
			0: return FLAG_START;
			1: return FLAG_ESC;
			2: return FLAG_SEP;
			3: return FLAG_START ^ ESC_XOR;
			4: return FLAG_ESC ^ ESC_XOR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void put_body(logic [7:0] v);
		if (v == FLAG_ESC || $urandom_range(0, 5) == 0) begin
			put_byte(FLAG_ESC);
			put_byte(v ^ ESC_XOR);
		end else begin
			put_byte(v);
		end
	endfunction

	function automatic void gen_frame(int lim, bit big);
		int          nlen;
		int          nbody;
		int          sel;
		int          i;
		logic [31:0] len;
		logic [1:0]  rep;
		logic [7:0]  b;
		put_byte(FLAG_START);
		sel = $urandom_range(0, 99);
		if (big)
			nlen = 0;
		else if (sel < 8)
			nlen = lim + 1;
		else if (sel < 12)
			nlen = lim;
		else
			nlen = $urandom_range(0, lim < 6 ? lim : 6);
		for (i = 0; i < nlen; i++) begin
			do b = any_byte(); while (b == FLAG_SEP);
			put_byte(b);
		end
		if (nlen > lim)
			return;
		put_byte(FLAG_SEP);
		sel = $urandom_range(0, 99);
		if (big)
			len = 32'd515;
		else if (sel < 6)
			len = '0;
		else if (sel < 12)
			len = $urandom | 32'h0001_0000;
		else
			len = $urandom_range(1, 12);
		for (i = 3; i >= 0; i--)
			put_byte(len[i*8 +: 8]);
		if (!big && $urandom_range(0, 19) == 0) begin
			do b = any_byte(); while (b == FLAG_SEP);
			put_byte(b);
			return;
		end
		sel = $urandom_range(0, 99);
		if (big || sel < 70)
			rep = REPLY_OK;
		else if (sel < 85)
			rep = REPLY_REFUSED;
		else if (sel < 95)
			rep = REPLY_OPEN_FAIL;
		else
			rep = REPLY_OTHER;
		put(KIND_BYTE, FLAG_SEP, rep);
		// zero and huge lengths never finish, cut them short by a timeout
		nbody = (len == 0 || len > 600) ? $urandom_range(1, 10) : len;
		if (!big && nbody == len && $urandom_range(0, 9) == 0)
			nbody = $urandom_range(0, nbody - 1);
		for (i = 0; i < nbody; i++)
			put_body(any_byte());
		if (nbody != len) begin
			put_timeout();
			return;
		end
		if ($urandom_range(0, 9) == 0) begin
			do b = any_byte(); while (b == FLAG_START);
			put_byte(b);
		end else begin
			put_byte(FLAG_START);
		end
	endfunction

	task automatic send(frame_row_t row);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur = row;
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, row.it.storage_reply, row.it.rx_byte};
		s_tuser <= row.it.kind;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic drive_all();
		while (rx_stream.size() != 0)
			send(rx_stream.pop_front());
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int lim, int pg, int target, bit big, bit txi, bit rxi);
		int sel;
		logic [7:0] b;
		while (pending_results.size() != 0)
			@(posedge clk);
		write_reg(REG_NAME_LIMIT, 16'(lim));
		write_reg(REG_PAGE_SIZE, 16'(pg));
		tx_idle = txi;
		rx_idle = rxi;
		if (big)
			gen_frame(lim, 1'b1);
		while (rx_stream.size() < target) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				put_timeout();
			end else if (sel == 1) begin
				do b = any_byte(); while (b == FLAG_START);
				put_byte(b);
			end
			gen_frame(lim, 1'b0);
		end
		drive_all();
	endtask

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED[i])
			rx_stream.push_back(DIRECTED[i]);
		drive_all();
		run_phase(63, 256, 15, 1'b0, 1'b1, 1'b1);
		run_phase(1, 1, 10, 1'b0, 1'b0, 1'b0);
		run_phase(0, 0, 1, 1'b1, 1'b0, 1'b1);
		run_phase(5, 3, 10, 1'b0, 1'b1, 1'b0);
		run_phase($urandom_range(2, 62), $urandom_range(2, 255), 10, 1'b0, 1'b1, 1'b1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_mismatch == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
